// File: design/sme_pkg.sv
package sme_pkg;

	localparam int unsigned STACK_DEPTH = 16;
	localparam int unsigned PC_WIDTH = 16;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [PC_WIDTH-1:0] pc_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef enum logic [3:0] {
		OP_PUSH       = 4'd0,
		OP_POP        = 4'd1,
		OP_SWAP       = 4'd2,
		OP_ROT        = 4'd3,
		OP_DUP        = 4'd4,
		OP_GET        = 4'd5,
		OP_PRINT      = 4'd6,
		OP_PRINTSTACK = 4'd7,
		OP_BTRUE      = 4'd8,
		OP_CMPI       = 4'd9,
		OP_HALT       = 4'd10,
		OP_ADD        = 4'd11,
		OP_SUB        = 4'd12,
		OP_MULT       = 4'd13,
		OP_NOT        = 4'd14,
		OP_ILLEGAL    = 4'd15
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_HALT    = 3'd1,
		ST_UNDER   = 3'd2,
		ST_OVER    = 3'd3,
		ST_ILLEGAL = 3'd4
	} status_t;

	// how the stack moves for one instruction
	typedef enum logic [2:0] {
		STK_HOLD,
		STK_PUSH,
		STK_POP,
		STK_POP_REPLACE,
		STK_REPLACE,
		STK_SWAP,
		STK_ROT
	} stk_op_t;

	typedef struct packed {
		stk_op_t op;
		word_t   value;
	} stk_cmd_t;

	typedef struct packed {
		word_t  top;
		word_t  second;
		word_t  third;
		count_t count;
	} stk_view_t;

	typedef struct packed {
		pc_t     next_pc;
		status_t status;
		logic    print_valid;
		word_t   print_value;
	} result_t;

endpackage

// File: design/sme_stack.sv
module sme_stack (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  sme_pkg::stk_cmd_t   cmd,
	output sme_pkg::stk_view_t  view
);

	sme_pkg::word_t  entry_q [sme_pkg::STACK_DEPTH];
	sme_pkg::count_t count_q;

	// shift line: entry 0 is the top of stack
	always_ff @(posedge clk) begin
		if (en) begin
			case (cmd.op)
				sme_pkg::STK_PUSH: begin
					entry_q[0] <= cmd.value;
					for (int i = 1; i < sme_pkg::STACK_DEPTH; i++) begin
						entry_q[i] <= entry_q[i-1];
					end
				end
				sme_pkg::STK_POP: begin
					for (int i = 0; i < sme_pkg::STACK_DEPTH - 1; i++) begin
						entry_q[i] <= entry_q[i+1];
					end
				end
				sme_pkg::STK_POP_REPLACE: begin
					entry_q[0] <= cmd.value;
					for (int i = 1; i < sme_pkg::STACK_DEPTH - 1; i++) begin
						entry_q[i] <= entry_q[i+1];
					end
				end
				sme_pkg::STK_REPLACE: begin
					entry_q[0] <= cmd.value;
				end
				sme_pkg::STK_SWAP: begin
					entry_q[0] <= entry_q[1];
					entry_q[1] <= entry_q[0];
				end
				sme_pkg::STK_ROT: begin
					entry_q[0] <= entry_q[2];
					entry_q[1] <= entry_q[0];
					entry_q[2] <= entry_q[1];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			case (cmd.op)
				sme_pkg::STK_PUSH: count_q <= count_q + sme_pkg::CNT_W'(1);
				sme_pkg::STK_POP,
				sme_pkg::STK_POP_REPLACE: count_q <= count_q - sme_pkg::CNT_W'(1);
				default: begin
				end
			endcase
		end
	end

	assign view.top    = entry_q[0];
	assign view.second = entry_q[1];
	assign view.third  = entry_q[2];
	assign view.count  = count_q;

endmodule

// File: design/sme_alu.sv
module sme_alu (
	input  logic [3:0]           func,
	input  logic signed [31:0]   operand,
	input  logic [15:0]          current_pc,
	input  logic signed [31:0]   get_value,
	input  sme_pkg::stk_view_t   view,
	output sme_pkg::result_t     res,
	output sme_pkg::stk_cmd_t    cmd
);

	logic [1:0]              need;
	logic                    grow;
	sme_pkg::status_t        status;
	sme_pkg::word_t          prod;
	logic [sme_pkg::CNT_W:0] grown;
	sme_pkg::pc_t            pc_inc;

	assign prod   = view.second * view.top;
	assign grown  = {1'b0, view.count} + (sme_pkg::CNT_W + 1)'(grow);
	assign pc_inc = current_pc + sme_pkg::PC_WIDTH'(1);

	// stack depth needed, growth and status per opcode
	always_comb begin
		need   = 2'd0;
		grow   = 1'b0;
		status = sme_pkg::ST_OK;
		unique case (sme_pkg::opcode_t'(func)) inside
			sme_pkg::OP_PUSH, sme_pkg::OP_GET: grow = 1'b1;
			sme_pkg::OP_POP, sme_pkg::OP_PRINT, sme_pkg::OP_PRINTSTACK,
			sme_pkg::OP_BTRUE, sme_pkg::OP_NOT: need = 2'd1;
			sme_pkg::OP_DUP, sme_pkg::OP_CMPI: begin
				need = 2'd1;
				grow = 1'b1;
			end
			sme_pkg::OP_SWAP, sme_pkg::OP_ADD, sme_pkg::OP_SUB,
			sme_pkg::OP_MULT: need = 2'd2;
			sme_pkg::OP_ROT: need = 2'd3;
			sme_pkg::OP_HALT: status = sme_pkg::ST_HALT;
			default: status = sme_pkg::ST_ILLEGAL;
		endcase
		if (status == sme_pkg::ST_OK) begin
			if (view.count < sme_pkg::CNT_W'(need)) begin
				status = sme_pkg::ST_UNDER;
			end else if (grown > (sme_pkg::CNT_W + 1)'(sme_pkg::STACK_DEPTH)) begin
				status = sme_pkg::ST_OVER;
			end
		end
	end

	always_comb begin
		res.next_pc     = current_pc;
		res.status      = status;
		res.print_valid = 1'b0;
		res.print_value = '0;
		cmd.op          = sme_pkg::STK_HOLD;
		cmd.value       = '0;
		if (status == sme_pkg::ST_OK) begin
			res.next_pc = pc_inc;
			unique case (sme_pkg::opcode_t'(func))
				sme_pkg::OP_PUSH: begin
					cmd.op    = sme_pkg::STK_PUSH;
					cmd.value = operand;
				end
				sme_pkg::OP_GET: begin
					cmd.op    = sme_pkg::STK_PUSH;
					cmd.value = get_value;
				end
				sme_pkg::OP_POP: cmd.op = sme_pkg::STK_POP;
				sme_pkg::OP_SWAP: cmd.op = sme_pkg::STK_SWAP;
				sme_pkg::OP_ROT: cmd.op = sme_pkg::STK_ROT;
				sme_pkg::OP_DUP: begin
					cmd.op    = sme_pkg::STK_PUSH;
					cmd.value = view.top;
				end
				sme_pkg::OP_PRINT: begin
					res.print_valid = 1'b1;
					res.print_value = view.top;
				end
				sme_pkg::OP_BTRUE: begin
					cmd.op = sme_pkg::STK_POP;
					if (view.top != '0) begin
						res.next_pc = current_pc + operand[sme_pkg::PC_WIDTH-1:0];
					end
				end
				sme_pkg::OP_CMPI: begin
					cmd.op    = sme_pkg::STK_PUSH;
					cmd.value = (view.top == operand) ? sme_pkg::WORD_W'(1) : '0;
				end
				sme_pkg::OP_ADD: begin
					cmd.op    = sme_pkg::STK_POP_REPLACE;
					cmd.value = view.second + view.top;
				end
				sme_pkg::OP_SUB: begin
					cmd.op    = sme_pkg::STK_POP_REPLACE;
					cmd.value = view.second - view.top;
				end
				sme_pkg::OP_MULT: begin
					cmd.op    = sme_pkg::STK_POP_REPLACE;
					cmd.value = prod;
				end
				sme_pkg::OP_NOT: begin
					cmd.op    = sme_pkg::STK_REPLACE;
					cmd.value = (view.top == '0) ? sme_pkg::WORD_W'(1) : '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: design/stack_machine_execute.sv
// an instruction is taken into the input register and executes from there; its result is
// captured in the result register, from which it transfers out
// throughput: one instruction per cycle, held back only by stall on the result side
// reset (arst_n low, asynchronous): both registers empty and the stack count cleared;
// stack entries are left as they are and only hold meaning once pushed
module stack_machine_execute (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [3:0]          func,
	input  logic signed [31:0]  operand,
	input  logic [15:0]         current_pc,
	input  logic signed [31:0]  get_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         next_pc,
	output logic [2:0]          status,
	output logic                print_valid,
	output logic signed [31:0]  print_value
);

	// input register
	logic                valid_s1;
	logic [3:0]          func_s1;
	logic signed [31:0]  operand_s1;
	logic [15:0]         pc_s1;
	logic signed [31:0]  get_value_s1;

	// result register
	logic                valid_s2;
	sme_pkg::result_t    res_s2;

	logic                out_free;
	logic                exec;
	sme_pkg::stk_view_t  view;
	sme_pkg::stk_cmd_t   cmd;
	sme_pkg::result_t    res;

	// result register can take a new value when empty or being transferred out
	assign out_free = !valid_s2 || !out_stall;
	// the instruction in the input register executes and commits to the stack
	assign exec     = valid_s1 && out_free;
	// input register refills when it is empty or its instruction moves on
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1      <= func;
			operand_s1   <= operand;
			pc_s1        <= current_pc;
			get_value_s1 <= get_value;
		end
	end

	// execute: decode, stack checks, arithmetic and next pc
	sme_alu u_alu (
		.func       (func_s1),
		.operand    (operand_s1),
		.current_pc (pc_s1),
		.get_value  (get_value_s1),
		.view       (view),
		.res        (res),
		.cmd        (cmd)
	);

	// operand stack; it moves at the same edge the result is captured, so the
	// next instruction already sees the updated top entries
	sme_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (exec),
		.cmd    (cmd),
		.view   (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign next_pc     = res_s2.next_pc;
	assign status      = res_s2.status;
	assign print_valid = res_s2.print_valid;
	assign print_value = res_s2.print_value;

endmodule
